FILE: rtl/cpo_pkg.sv
// Package for the circle pair overlap unit: widths, stage counts and the
// request structures passed between pipeline stages. No dependencies.
`timescale 1ns / 1ps
package cpo_pkg;
    localparam int CoordW  = 24;
    localparam int RadW    = 16;
    localparam int MagW    = 17;
    localparam int D2W     = 2 * MagW;
    localparam int RemSqW  = MagW + 1;
    localparam int RemDivW = MagW + 1;
    localparam int NormW   = 16;
    localparam int DepthW  = 17;
    localparam int SqrtStages = MagW;
    localparam int DivStages  = NormW;
    localparam logic [D2W:0] Dist2MinExcl = (D2W + 1)'(6);

    typedef struct packed {
        logic [D2W-1:0]    d2;
        logic [RemSqW-1:0] rem;
        logic [MagW-1:0]   root;
        logic [MagW-1:0]   mx;
        logic [MagW-1:0]   my;
        logic              sx;
        logic              sy;
        logic [MagW-1:0]   rs;
        logic              ov;
    } cpo_sq_t;

    typedef struct packed {
        logic [RemDivW-1:0] remx;
        logic [RemDivW-1:0] remy;
        logic [NormW-1:0]   qx;
        logic [NormW-1:0]   qy;
        logic [MagW-1:0]    dist_root;
        logic               sx;
        logic               sy;
        logic [MagW-1:0]    rs;
        logic               ov;
    } cpo_dv_t;
endpackage

FILE: rtl/cpo_front.sv
// Front end: differences, magnitudes, squares and the overlap test over
// four register stages. Depends on cpo_pkg.
`timescale 1ns / 1ps
module cpo_front
    import cpo_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic signed [CoordW-1:0] ax,
    input  logic signed [CoordW-1:0] ay,
    input  logic [RadW-1:0]          ar,
    input  logic signed [CoordW-1:0] bx,
    input  logic signed [CoordW-1:0] by,
    input  logic [RadW-1:0]          br,
    output logic                     out_valid,
    output cpo_sq_t                  out_data
);
    logic [3:0] vld_reg;
    logic signed [CoordW:0] dx_reg, dy_reg, dx_next, dy_next;
    logic [MagW-1:0] rs1_reg, rs2_reg, rs3_reg;
    logic [MagW-1:0] mx_reg, my_reg, mx_next, my_next, mx3_reg, my3_reg;
    logic sx_reg, sy_reg, sx3_reg, sy3_reg, big_reg, big3_reg, big_next;
    logic [D2W-1:0] sqx_reg, sqy_reg, rsq_reg;
    logic [D2W:0] d2_sum;
    logic [CoordW:0] adx, ady;
    cpo_sq_t q_reg;

    assign dx_next = (CoordW + 1)'(bx) - (CoordW + 1)'(ax);
    assign dy_next = (CoordW + 1)'(by) - (CoordW + 1)'(ay);
    assign adx = dx_reg[CoordW] ? -dx_reg : dx_reg;
    assign ady = dy_reg[CoordW] ? -dy_reg : dy_reg;
    assign big_next = (adx[CoordW:MagW] != '0) || (ady[CoordW:MagW] != '0);
    assign mx_next = adx[MagW-1:0];
    assign my_next = ady[MagW-1:0];
    assign d2_sum = (D2W + 1)'(sqx_reg) + (D2W + 1)'(sqy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            rs1_reg  <= MagW'(ar) + MagW'(br);
            mx_reg   <= mx_next;
            my_reg   <= my_next;
            sx_reg   <= dx_reg[CoordW];
            sy_reg   <= dy_reg[CoordW];
            big_reg  <= big_next;
            rs2_reg  <= rs1_reg;
            sqx_reg  <= mx_reg * mx_reg;
            sqy_reg  <= my_reg * my_reg;
            rsq_reg  <= rs2_reg * rs2_reg;
            mx3_reg  <= mx_reg;
            my3_reg  <= my_reg;
            sx3_reg  <= sx_reg;
            sy3_reg  <= sy_reg;
            big3_reg <= big_reg;
            rs3_reg  <= rs2_reg;
            q_reg.d2   <= d2_sum[D2W-1:0];
            q_reg.rem  <= '0;
            q_reg.root <= '0;
            q_reg.mx   <= mx3_reg;
            q_reg.my   <= my3_reg;
            q_reg.sx   <= sx3_reg;
            q_reg.sy   <= sy3_reg;
            q_reg.rs   <= rs3_reg;
            q_reg.ov   <= !big3_reg && (d2_sum < (D2W + 1)'(rsq_reg))
                          && (d2_sum > Dist2MinExcl);
        end
    end

    assign out_valid = vld_reg[3];
    assign out_data  = q_reg;
endmodule

FILE: rtl/cpo_sqrt_stage.sv
// One digit of the integer square root; the radicand shifts two bits a stage.
// Depends on cpo_pkg.
`timescale 1ns / 1ps
module cpo_sqrt_stage
    import cpo_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  logic    in_valid,
    input  cpo_sq_t in_data,
    output logic    out_valid,
    output cpo_sq_t out_data
);
    logic valid_reg;
    cpo_sq_t data_reg, data_next;
    logic [RemSqW+1:0] rem_sh, trial;

    assign rem_sh = {in_data.rem, in_data.d2[D2W-1:D2W-2]};
    assign trial  = {1'b0, in_data.root, 2'b01};

    always_comb
    begin
        data_next = in_data;
        data_next.d2 = {in_data.d2[D2W-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            data_next.rem  = RemSqW'(rem_sh - trial);
            data_next.root = {in_data.root[MagW-2:0], 1'b1};
        end
        else
        begin
            data_next.rem  = RemSqW'(rem_sh);
            data_next.root = {in_data.root[MagW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

FILE: rtl/cpo_div_stage.sv
// One quotient bit of both normal components by restoring division.
// Depends on cpo_pkg.
`timescale 1ns / 1ps
module cpo_div_stage
    import cpo_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  logic    in_valid,
    input  cpo_dv_t in_data,
    output logic    out_valid,
    output cpo_dv_t out_data
);
    logic valid_reg;
    cpo_dv_t data_reg, data_next;
    logic [RemDivW-1:0] dd, rx, ry;
    logic bx, by;

    assign dd = RemDivW'(in_data.dist_root);
    assign bx = in_data.remx >= dd;
    assign by = in_data.remy >= dd;
    assign rx = bx ? in_data.remx - dd : in_data.remx;
    assign ry = by ? in_data.remy - dd : in_data.remy;

    always_comb
    begin
        data_next = in_data;
        data_next.remx = {rx[RemDivW-2:0], 1'b0};
        data_next.remy = {ry[RemDivW-2:0], 1'b0};
        data_next.qx   = {in_data.qx[NormW-2:0], bx};
        data_next.qy   = {in_data.qy[NormW-2:0], by};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

FILE: rtl/circle_pair_overlap_unit.sv
// Top level of the circle pair overlap unit: front end, square root and
// division pipelines, output register. Depends on cpo_pkg and the cpo_ modules.
// One request of two circles enters every cycle unless the output stalls, and yields one result
// through 4 front stages, 17 square root stages, 16 division stages and 1 output register.
// The whole pipeline advances while the output register is empty or being taken,
// so a stall at m_tready holds every stage and s_tready falls with it.
`timescale 1ns / 1ps
module circle_pair_overlap_unit
    import cpo_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // first_x, first_y, first_radius, second_x, second_y, second_radius
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // overlap, normal_x, normal_y, depth, zero fill
    output logic [55:0]  m_tdata
);
    logic en;
    logic sq_vld [SqrtStages+1];
    cpo_sq_t sq_dat [SqrtStages+1];
    logic dv_vld [DivStages+1];
    cpo_dv_t dv_dat [DivStages+1];
    logic out_valid_reg;
    logic [55:0] out_data_reg, out_data_next;
    cpo_dv_t fin;
    logic [NormW-1:0] nx, ny;

    assign en = !out_valid_reg || m_tready;
    assign s_tready = en;

    cpo_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .ax        (s_tdata[23:0]),
        .ay        (s_tdata[47:24]),
        .ar        (s_tdata[63:48]),
        .bx        (s_tdata[87:64]),
        .by        (s_tdata[111:88]),
        .br        (s_tdata[127:112]),
        .out_valid (sq_vld[0]),
        .out_data  (sq_dat[0])
    );

    for (genvar i = 0; i < SqrtStages; i++)
    begin : g_sqrt
        cpo_sqrt_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sq_vld[i]),
            .in_data   (sq_dat[i]),
            .out_valid (sq_vld[i+1]),
            .out_data  (sq_dat[i+1])
        );
    end

    assign dv_vld[0] = sq_vld[SqrtStages];
    assign dv_dat[0] = '{
        remx:      RemDivW'(sq_dat[SqrtStages].mx),
        remy:      RemDivW'(sq_dat[SqrtStages].my),
        qx:        '0,
        qy:        '0,
        dist_root: sq_dat[SqrtStages].root,
        sx:        sq_dat[SqrtStages].sx,
        sy:        sq_dat[SqrtStages].sy,
        rs:        sq_dat[SqrtStages].rs,
        ov:        sq_dat[SqrtStages].ov
    };

    for (genvar i = 0; i < DivStages; i++)
    begin : g_div
        cpo_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (dv_vld[i]),
            .in_data   (dv_dat[i]),
            .out_valid (dv_vld[i+1]),
            .out_data  (dv_dat[i+1])
        );
    end

    assign fin = dv_dat[DivStages];
    // positive full scale saturates; negative full scale is representable
    assign nx = fin.sx ? -fin.qx : (fin.qx[NormW-1] ? {1'b0, {(NormW-1){1'b1}}} : fin.qx);
    assign ny = fin.sy ? -fin.qy : (fin.qy[NormW-1] ? {1'b0, {(NormW-1){1'b1}}} : fin.qy);

    always_comb
    begin
        out_data_next = '0;
        if (fin.ov)
        begin
            out_data_next[0]     = 1'b1;
            out_data_next[16:1]  = nx;
            out_data_next[32:17] = ny;
            out_data_next[49:33] = DepthW'(fin.rs - fin.dist_root);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_vld[DivStages];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
endmodule

FILE: rtl/cpo_checker.sv
// Port-level checks for circle_pair_overlap_unit, attached by bind.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
module cpo_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [55:0]  m_tdata
);
    a_zero_when_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[55:1] == '0))
        else $error("non-overlap result carries data");

    a_depth_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[49:33] != '0))
        else $error("overlap with zero depth");

    a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");
endmodule

bind circle_pair_overlap_unit cpo_checker u_cpo_checker (.*);
